// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define ASSERT_ON(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_ON(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/dac_pkg.sv =====
`timescale 1ns / 1ps
// Package: constants and types of the dihedral angle check unit.
package dac_pkg;

    localparam int COORD_WIDTH_DEF = 16;   // default coordinate width
    localparam int NUM_COORDS      = 12;   // four points, three axes
    localparam int MUL_LIMB_W      = 32;   // limb width of the split multipliers
    localparam int MUL_STAGES      = 3;    // partial products, row sums, final sum
    localparam int COS_W           = 16;   // signed squared cosine, Q1.14
    localparam int COS_FRAC        = 14;
    localparam int CFG_IDX_W       = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECK_ENABLE = 1'b0,
        REG_COS_LIMIT    = 1'b1
    } cfg_reg_t;

endpackage

// ===== rtl/dac_mul.sv =====
`timescale 1ns / 1ps
// Pipelined signed multiplier split into limbs, three register stages.
module dac_mul #(
    parameter int A_W = 17,
    parameter int B_W = 17
) (
    input  logic                            aclk,
    input  logic [dac_pkg::MUL_STAGES-1:0]  en,   // load enable per stage
    input  logic signed [A_W-1:0]           a,
    input  logic signed [B_W-1:0]           b,
    output logic signed [A_W+B_W-1:0]       p
);

    localparam int L    = dac_pkg::MUL_LIMB_W;
    localparam int NA   = (A_W + L - 1) / L;
    localparam int NB   = (B_W + L - 1) / L;
    localparam int P_W  = A_W + B_W;
    localparam int PP_W = 2 * L + 2;

    logic signed [NA*L-1:0] a_ext;
    logic signed [NB*L-1:0] b_ext;
    logic signed [L:0]      a_limb [NA];
    logic signed [L:0]      b_limb [NB];
    logic signed [PP_W-1:0] pp_reg [NA][NB];
    logic signed [P_W-1:0]  row_next [NA];
    logic signed [P_W-1:0]  row_reg [NA];
    logic signed [P_W-1:0]  p_next;
    logic signed [P_W-1:0]  p_reg;

    assign a_ext = (NA*L)'(a);
    assign b_ext = (NB*L)'(b);

    // top limb carries the sign, lower limbs are unsigned
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_limb[i] = $signed({a_ext[i*L+L-1], a_ext[i*L +: L]});
            end else begin
                a_limb[i] = $signed({1'b0, a_ext[i*L +: L]});
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_limb[j] = $signed({b_ext[j*L+L-1], b_ext[j*L +: L]});
            end else begin
                b_limb[j] = $signed({1'b0, b_ext[j*L +: L]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_limb[i] * b_limb[j];
                end
            end
        end
    end

    // sums run modulo 2^P_W; the true product fits
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (P_W'(pp_reg[i][j]) <<< (j * L));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            row_reg <= row_next;
        end
    end

    always_comb begin
        p_next = '0;
        for (int i = 0; i < NA; i++) begin
            p_next = p_next + (row_reg[i] <<< (i * L));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/dihedral_angle_check_unit.sv =====
`timescale 1ns / 1ps
// Top level: pipelined dihedral angle and fold test for triangle pairs.
//
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   12 coordinates p1_x..p4_z, COORD_WIDTH each
// m_        out  m_tvalid/m_tready   angle_exceeded, folded_side, violation
// cfg_      in   cfg_we              cfg_idx selects register, cfg_wdata value
//
// One transaction per cycle unless the output stalls; register stages:
// differences, normals, sums, |A.B| and result, plus four chained three-stage
// limb multipliers (cross terms, dot terms, squares, limit product).
// Reset (aresetn, synchronous) empties the pipeline and clears both registers.
// A stalled output holds; empty stages upstream still fill, so s_tready drops
// only when every stage holds a transaction and m_tready is low.
`include "assert_macros.svh"

module dihedral_angle_check_unit #(
    parameter int COORD_WIDTH = dac_pkg::COORD_WIDTH_DEF,
    localparam int S_TDATA_W  = ((dac_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [dac_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [dac_pkg::COS_W-1:0]      cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z
    input  logic [S_TDATA_W-1:0]           s_tdata,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // angle_exceeded, folded_side, violation, zero fill
    output logic [M_TDATA_W-1:0]           m_tdata
);

    // ---------------------------------------------------------------
    // Widths, full precision throughout
    // ---------------------------------------------------------------
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;            // edge difference
    localparam int PW1  = 2 * DW;           // cross product term
    localparam int CW   = PW1 + 1;          // normal component
    localparam int PW2  = 2 * CW;           // normal by normal term
    localparam int DOTW = PW2 + 2;          // dot product, squared lengths
    localparam int ADW  = CW + DW;          // normal by edge term
    localparam int TW   = ADW + 2;          // A . d42
    localparam int SQW  = 2 * DOTW;         // dot*|dot|, |A|^2*|B|^2
    localparam int CLLW = SQW + dac_pkg::COS_W;
    localparam int FW   = SQW + 17;         // final weighted sum

    // stage numbers
    localparam int MS       = dac_pkg::MUL_STAGES;
    localparam int ST_DIFF  = 0;
    localparam int ST_NORM  = ST_DIFF + MS + 1;
    localparam int ST_SUM   = ST_NORM + MS + 1;
    localparam int ST_ABS   = ST_SUM + 1;
    localparam int ST_SQ    = ST_ABS + MS;
    localparam int ST_CLL   = ST_SQ + MS;
    localparam int ST_OUT   = ST_CLL + 1;
    localparam int NSTG     = ST_OUT + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic                              check_enable_reg;
    logic signed [dac_pkg::COS_W-1:0]  cos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_enable_reg <= 1'b0;
            cos_reg          <= '0;
        end else if (cfg_we) begin
            case (dac_pkg::cfg_reg_t'(cfg_idx))
                dac_pkg::REG_CHECK_ENABLE: check_enable_reg <= cfg_wdata[0];
                dac_pkg::REG_COS_LIMIT:    cos_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or the stage
    // after it moves on, so bubbles collapse under a stall.
    // ---------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;
    logic            blocked;

    always_comb begin
        blocked = !m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            blocked = blocked && vld_reg[k];
            en[k]   = !blocked;
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[ST_OUT];

    // ---------------------------------------------------------------
    // Stage 0: edge differences d21, d32, d42
    // ---------------------------------------------------------------
    logic signed [W-1:0]  crd [dac_pkg::NUM_COORDS];
    logic signed [DW-1:0] diff_reg [3][3];   // [0] d21, [1] d32, [2] d42

    always_comb begin
        for (int i = 0; i < dac_pkg::NUM_COORDS; i++) begin
            crd[i] = $signed(s_tdata[i*W +: W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_DIFF]) begin
            for (int r = 0; r < 3; r++) begin
                diff_reg[0][r] <= DW'(crd[3+r]) - DW'(crd[r]);
                diff_reg[1][r] <= DW'(crd[6+r]) - DW'(crd[3+r]);
                diff_reg[2][r] <= DW'(crd[9+r]) - DW'(crd[3+r]);
            end
        end
    end

    // d42 rides along until the normals are ready
    logic signed [DW-1:0] d42_pipe_reg [1:ST_NORM][3];

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= ST_NORM; k++) begin
            if (en[k]) begin
                if (k == 1) begin
                    d42_pipe_reg[k] <= diff_reg[2];
                end else begin
                    d42_pipe_reg[k] <= d42_pipe_reg[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 1-3: cross product terms. A = d21 x d32, B = d42 x d32
    // ---------------------------------------------------------------
    logic signed [PW1-1:0] xp_pos [2][3];
    logic signed [PW1-1:0] xp_neg [2][3];

    for (genvar n = 0; n < 2; n++) begin : g_nrm
        for (genvar r = 0; r < 3; r++) begin : g_cmp
            dac_mul #(.A_W(DW), .B_W(DW)) u_pos (
                .aclk (aclk),
                .en   (en[ST_DIFF+1 +: MS]),
                .a    (diff_reg[2*n][(r+1)%3]),
                .b    (diff_reg[1][(r+2)%3]),
                .p    (xp_pos[n][r])
            );
            dac_mul #(.A_W(DW), .B_W(DW)) u_neg (
                .aclk (aclk),
                .en   (en[ST_DIFF+1 +: MS]),
                .a    (diff_reg[2*n][(r+2)%3]),
                .b    (diff_reg[1][(r+1)%3]),
                .p    (xp_neg[n][r])
            );
        end
    end

    // Stage 4: normal components
    logic signed [CW-1:0] nrm_reg [2][3];

    always_ff @(posedge aclk) begin
        if (en[ST_NORM]) begin
            for (int n = 0; n < 2; n++) begin
                for (int r = 0; r < 3; r++) begin
                    nrm_reg[n][r] <= CW'(xp_pos[n][r]) - CW'(xp_neg[n][r]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 5-7: A.B, |A|^2, |B|^2 and A.d42 terms.
    // d32 . (A x B) = -|d32|^2 (A . d42), so the fold test needs only A . d42.
    // ---------------------------------------------------------------
    logic signed [PW2-1:0] ab_p [3];
    logic signed [PW2-1:0] aa_p [3];
    logic signed [PW2-1:0] bb_p [3];
    logic signed [ADW-1:0] ad_p [3];

    for (genvar r = 0; r < 3; r++) begin : g_dot
        dac_mul #(.A_W(CW), .B_W(CW)) u_ab (
            .aclk (aclk),
            .en   (en[ST_NORM+1 +: MS]),
            .a    (nrm_reg[0][r]),
            .b    (nrm_reg[1][r]),
            .p    (ab_p[r])
        );
        dac_mul #(.A_W(CW), .B_W(CW)) u_aa (
            .aclk (aclk),
            .en   (en[ST_NORM+1 +: MS]),
            .a    (nrm_reg[0][r]),
            .b    (nrm_reg[0][r]),
            .p    (aa_p[r])
        );
        dac_mul #(.A_W(CW), .B_W(CW)) u_bb (
            .aclk (aclk),
            .en   (en[ST_NORM+1 +: MS]),
            .a    (nrm_reg[1][r]),
            .b    (nrm_reg[1][r]),
            .p    (bb_p[r])
        );
        dac_mul #(.A_W(CW), .B_W(DW)) u_ad (
            .aclk (aclk),
            .en   (en[ST_NORM+1 +: MS]),
            .a    (nrm_reg[0][r]),
            .b    (d42_pipe_reg[ST_NORM][r]),
            .p    (ad_p[r])
        );
    end

    // Stage 8: three-term sums
    logic signed [DOTW-1:0] dot_reg;
    logic signed [DOTW-1:0] la_reg;
    logic signed [DOTW-1:0] lb_reg;
    logic signed [TW-1:0]   tri_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            dot_reg <= DOTW'(ab_p[0]) + DOTW'(ab_p[1]) + DOTW'(ab_p[2]);
            la_reg  <= DOTW'(aa_p[0]) + DOTW'(aa_p[1]) + DOTW'(aa_p[2]);
            lb_reg  <= DOTW'(bb_p[0]) + DOTW'(bb_p[1]) + DOTW'(bb_p[2]);
            tri_reg <= TW'(ad_p[0]) + TW'(ad_p[1]) + TW'(ad_p[2]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 9: |A.B| and the fold flag (A . d42 > 0)
    // ---------------------------------------------------------------
    logic signed [DOTW-1:0] dot9_reg;
    logic signed [DOTW-1:0] absdot_reg;
    logic signed [DOTW-1:0] la9_reg;
    logic signed [DOTW-1:0] lb9_reg;
    logic                   fold_pipe_reg [ST_ABS:ST_CLL];

    always_ff @(posedge aclk) begin
        if (en[ST_ABS]) begin
            dot9_reg   <= dot_reg;
            absdot_reg <= dot_reg[DOTW-1] ? -dot_reg : dot_reg;
            la9_reg    <= la_reg;
            lb9_reg    <= lb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = ST_ABS; k <= ST_CLL; k++) begin
            if (en[k]) begin
                if (k == ST_ABS) begin
                    fold_pipe_reg[k] <= !tri_reg[TW-1] && (tri_reg != '0);
                end else begin
                    fold_pipe_reg[k] <= fold_pipe_reg[k-1];
                end
            end
        end
    end

    // Stages 10-12: (A.B)|A.B| and |A|^2 |B|^2
    logic signed [SQW-1:0] sq_p;
    logic signed [SQW-1:0] ll_p;

    dac_mul #(.A_W(DOTW), .B_W(DOTW)) u_sq (
        .aclk (aclk),
        .en   (en[ST_ABS+1 +: MS]),
        .a    (dot9_reg),
        .b    (absdot_reg),
        .p    (sq_p)
    );

    dac_mul #(.A_W(DOTW), .B_W(DOTW)) u_ll (
        .aclk (aclk),
        .en   (en[ST_ABS+1 +: MS]),
        .a    (la9_reg),
        .b    (lb9_reg),
        .p    (ll_p)
    );

    // Stages 13-15: limit times squared lengths; signed square waits alongside
    logic signed [CLLW-1:0] cll_p;
    logic signed [SQW-1:0]  sq_pipe_reg [ST_SQ+1:ST_CLL];

    dac_mul #(.A_W(SQW), .B_W(dac_pkg::COS_W)) u_cll (
        .aclk (aclk),
        .en   (en[ST_SQ+1 +: MS]),
        .a    (ll_p),
        .b    (cos_reg),
        .p    (cll_p)
    );

    always_ff @(posedge aclk) begin
        for (int k = ST_SQ + 1; k <= ST_CLL; k++) begin
            if (en[k]) begin
                if (k == ST_SQ + 1) begin
                    sq_pipe_reg[k] <= sq_p;
                end else begin
                    sq_pipe_reg[k] <= sq_pipe_reg[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 16: weighted sum sign and result register
    // W = (A.B)|A.B| * 2^14 + c |A|^2 |B|^2
    // ---------------------------------------------------------------
    logic signed [FW-1:0] wsum;
    logic                 out_angle_reg;
    logic                 out_fold_reg;
    logic                 out_viol_reg;

    assign wsum = (FW'(sq_pipe_reg[ST_CLL]) <<< dac_pkg::COS_FRAC) + FW'(cll_p);

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            out_angle_reg <= wsum[FW-1];
            out_fold_reg  <= fold_pipe_reg[ST_CLL];
            out_viol_reg  <= check_enable_reg && wsum[FW-1] && fold_pipe_reg[ST_CLL];
        end
    end

    assign m_tdata = {{(M_TDATA_W-3){1'b0}}, out_viol_reg, out_fold_reg, out_angle_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "output valid right after reset")
    `ASSERT_ON(a_viol_en, aclk, aresetn, (m_tvalid && m_tdata[2]) |-> check_enable_reg, "violation while check disabled")
    `ASSERT_ON(a_full_stall, aclk, aresetn, !s_tready |-> (&vld_reg && !m_tready), "input stalled with an empty stage")
    `ASSERT_ON(a_sum_hold, aclk, aresetn, (vld_reg[ST_SUM] && !en[ST_SUM]) |=> (vld_reg[ST_SUM] && $stable(dot_reg)), "stalled stage lost its transaction")

endmodule
